### rtl/assert_macros.svh
// assertion macros used by the allocator sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// an antecedent that implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ffua_pkg.sv
// shared constants and types of the first-fit unit allocator
package ffua_pkg;
    localparam int POOL_UNITS = 32768;
    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = (POOL_UNITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int UNIT_W     = $clog2(POOL_UNITS) + 1;
    localparam logic [15:0] POOL_RESET = 16'd20000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [UNIT_W-1:0]    t_unit;

    // memory port bundle from the sequencer to the map ram
    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
        t_word wr_data;
    } t_mem_req;

    // mask of bits lo..hi within a word, lo <= hi
    function automatic t_word range_mask(input logic [BIT_W-1:0] lo,
                                         input logic [BIT_W-1:0] hi);
        t_word m;
        m = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
            m[k] = (k >= int'(lo)) && (k <= int'(hi));
        end
        return m;
    endfunction
endpackage

### rtl/ffua_ram.sv
// generic single-port-write, registered-read ram
module ffua_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### rtl/ffua_seq.sv
// request sequencer: clear pass, first-fit scan and run marking or freeing over the map ram
`include "assert_macros.svh"
module ffua_seq import ffua_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_op,
    input  logic [15:0] i_alloc_size,
    input  logic [14:0] i_free_start,
    input  logic [15:0] i_free_length,
    input  logic [15:0] i_pool_size,
    input  t_word       i_rd_data,
    output t_mem_req    o_mem,
    output logic        o_busy,
    output logic        o_done,
    output logic        o_ok,
    output logic [14:0] o_block_start,
    output logic [14:0] o_block_end
);
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_BIT   = 7'b0001000,
        S_MRD   = 7'b0010000,
        S_MWR   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_addr  r_waddr, n_waddr;          // word under work
    t_unit  r_unit,  n_unit;           // unit scan position
    t_unit  r_run,   n_run;
    t_unit  r_first, n_first;
    t_unit  r_last,  n_last;
    t_unit  r_pool;
    t_unit  r_size;
    logic   r_op, r_ok, n_ok;
    t_word  r_word, n_word;
    logic   r_done, n_done;

    t_unit  pool_c;
    logic [16:0] free_end;
    logic [BIT_W-1:0] lo, hi;
    logic   first_word;
    logic   last_word;

    assign pool_c = (i_pool_size > 16'(POOL_UNITS)) ? t_unit'(POOL_UNITS)
                                                     : t_unit'(i_pool_size);
    assign free_end = 17'(i_free_start) + 17'(i_free_length);

    // mark range inside the current word
    assign first_word = r_first[UNIT_W-1:BIT_W] == (UNIT_W-BIT_W)'(r_waddr);
    assign last_word  = r_last[UNIT_W-1:BIT_W] == (UNIT_W-BIT_W)'(r_waddr);
    assign lo = first_word ? r_first[BIT_W-1:0] : '0;
    assign hi = last_word ? r_last[BIT_W-1:0] : '1;

    always_comb begin
        n_state = r_state;
        n_waddr = r_waddr;
        n_unit  = r_unit;
        n_run   = r_run;
        n_first = r_first;
        n_last  = r_last;
        n_ok    = r_ok;
        n_word  = r_word;
        n_done  = 1'b0;
        o_mem   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_waddr;
                o_mem.wr_data = '0;
                n_waddr = r_waddr + 1'b1;
                if (r_waddr == t_addr'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_unit = '0;
                    n_run  = '0;
                    n_ok   = 1'b0;
                    n_first = '0;
                    n_last  = '0;
                    n_waddr = '0;
                    if (i_op == OP_ALLOC) begin
                        if (i_alloc_size != '0 && pool_c != '0) begin
                            o_mem.rd_en = 1'b1;
                            o_mem.rd_addr = '0;
                            n_state = S_SCAN;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else if (i_free_length != '0 && free_end <= 17'(pool_c)) begin
                        n_first = t_unit'(i_free_start);
                        n_last  = t_unit'(free_end - 17'd1);
                        n_waddr = i_free_start[14:BIT_W];
                        o_mem.rd_en = 1'b1;
                        o_mem.rd_addr = i_free_start[14:BIT_W];
                        n_state = S_MRD;
                        n_ok = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // ram data for r_waddr arrives this cycle
                n_word  = i_rd_data;
                n_state = S_BIT;
            end
            S_BIT: begin
                // one unit per cycle from the latched word, pausing at each word boundary to load the next word
                if (r_unit >= r_pool) begin
                    n_state = S_DONE;
                end else if (r_word[r_unit[BIT_W-1:0]]) begin
                    n_run = '0;
                end else begin
                    n_run = r_run + 1'b1;
                end
                if (r_unit < r_pool) begin
                    if (!r_word[r_unit[BIT_W-1:0]] && (r_run + 1'b1) == r_size) begin
                        n_ok    = 1'b1;
                        n_last  = r_unit;
                        n_first = r_unit + 1'b1 - r_size;
                        n_waddr = n_first[ADDR_W+BIT_W-1:BIT_W];
                        o_mem.rd_en = 1'b1;
                        o_mem.rd_addr = n_first[ADDR_W+BIT_W-1:BIT_W];
                        n_state = S_MRD;
                    end else begin
                        n_unit = r_unit + 1'b1;
                        if (r_unit[BIT_W-1:0] == '1) begin
                            n_waddr = r_waddr + 1'b1;
                            o_mem.rd_en = (r_unit + 1'b1) < r_pool;
                            o_mem.rd_addr = r_waddr + 1'b1;
                            n_state = S_SCAN;
                            if ((r_unit + 1'b1) >= r_pool) begin
                                n_state = S_DONE;
                            end
                        end
                    end
                end
            end
            S_MRD: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_waddr;
                o_mem.wr_data = (r_op == OP_FREE) ? (i_rd_data & ~range_mask(lo, hi))
                                                  : (i_rd_data | range_mask(lo, hi));
                if (last_word) begin
                    n_state = S_DONE;
                end else begin
                    n_waddr = r_waddr + 1'b1;
                    o_mem.rd_en = 1'b1;
                    o_mem.rd_addr = r_waddr + 1'b1;
                    n_state = S_MRD;
                end
            end
            S_DONE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_waddr <= '0;
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_waddr <= n_waddr;
            r_done  <= n_done;
            r_ok    <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit  <= n_unit;
        r_run   <= n_run;
        r_first <= n_first;
        r_last  <= n_last;
        r_word  <= n_word;
        if (r_state == S_IDLE && i_start) begin
            r_op   <= i_op;
            r_pool <= pool_c;
            r_size <= (i_alloc_size > 16'(POOL_UNITS)) ? t_unit'(POOL_UNITS) + 1'b1
                                                        : t_unit'(i_alloc_size);
        end
    end

    assign o_busy        = r_state != S_IDLE;
    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_block_start = r_ok ? r_first[14:0] : '0;
    assign o_block_end   = r_ok ? r_last[14:0]  : '0;

    `ASSERT_ALWAYS(a_done_idle, i_clk, i_rst_n, !r_done || r_state == S_IDLE)
    `ASSERT_NEXT(a_mwr_write, i_clk, i_rst_n, r_state == S_MRD, r_state == S_MWR)
    `ASSERT_ALWAYS(a_ok_order, i_clk, i_rst_n, !(r_done && r_ok) || r_first <= r_last)
endmodule

### rtl/first_fit_unit_allocator.sv
// top level of the first-fit unit allocator
// usage:
//   requests are items on i_op, i_alloc_size, i_free_start, i_free_length;
//   an item is taken at a clock edge with start high and busy low.
//   each item yields one result on o_ok, o_block_start, o_block_end, shown
//   for one cycle with o_done high; the receiver cannot stall it.
//   pool_size is written over i_cfg_valid / o_cfg_ready / i_cfg_data;
//   o_cfg_ready is low while an item is in flight.
// operation:
//   the used map sits in a 512 x 64 ram. an allocate loads a word and then
//   tests one unit per cycle, reloading at each word boundary, up to the end
//   of the fitting run or of the pool; it then reads and rewrites each word
//   of the run to mark it. a free reads and rewrites each word touched.
//   every item then passes through a done state and o_done is high the
//   cycle after; a refused item holds busy for one cycle.
// reset:
//   synchronous active-low reset starts a clearing pass that zeroes all 512
//   words of the map; busy stays high during it. pool_size resets to 20000.
module first_fit_unit_allocator import ffua_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [15:0] i_alloc_size,
    input  logic [14:0] i_free_start,
    input  logic [15:0] i_free_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output logic        o_ok,
    output logic [14:0] o_block_start,
    output logic [14:0] o_block_end
);
    logic [15:0] r_pool_size;
    t_mem_req    mem;
    t_word       rd_data;

    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= POOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pool_size <= i_cfg_data;
        end
    end

    ffua_seq u_seq (
        .i_clk, .i_rst_n,
        .i_start       (start),
        .i_op, .i_alloc_size, .i_free_start, .i_free_length,
        .i_pool_size   (r_pool_size),
        .i_rd_data     (rd_data),
        .o_mem         (mem),
        .o_busy        (busy),
        .o_done, .o_ok, .o_block_start, .o_block_end
    );

    ffua_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
        .i_clk,
        .i_wr_en   (mem.wr_en),
        .i_wr_addr (mem.wr_addr),
        .i_wr_data (mem.wr_data),
        .i_rd_en   (mem.rd_en),
        .i_rd_addr (mem.rd_addr),
        .o_rd_data (rd_data)
    );
endmodule
